>>> design/kmcd_pkg.sv
// Shared constants and controller/datapath interface types for the key matrix
// change detector. No dependencies.
package kmcd_pkg;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    localparam int CFG_W  = 5;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_ROW_FIRST = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [1:0] REG_COL_COUNT = 2'd2;

    localparam logic [CFG_W-1:0] ROW_FIRST_RST = 5'd0;
    localparam logic [CFG_W-1:0] ROW_COUNT_RST = 5'd8;
    localparam logic [CFG_W-1:0] COL_COUNT_RST = 5'd8;

    localparam logic REQ_SCAN     = 1'b0;
    localparam logic REQ_SNAPSHOT = 1'b1;

    typedef struct packed {
        logic load;   // take the input beat
        logic emit;   // move the next event into the output register
    } kmcd_cmd_t;

    typedef struct packed {
        logic hit;        // the beat at the input produces events
        logic last;       // the event about to be emitted is the final one
        logic out_ready;  // output register free or draining this cycle
    } kmcd_sts_t;

endpackage

>>> design/kmcd_ctrl.sv
// Controller for the key matrix change detector: sequences accept and event
// emission. Depends on kmcd_pkg.
module kmcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  kmcd_pkg::kmcd_sts_t sts,
    output kmcd_pkg::kmcd_cmd_t cmd
);
    import kmcd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.hit)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/kmcd_dp.sv
// Datapath for the key matrix change detector: configuration registers,
// stored column rows, change mask, event pick and output register.
// Depends on kmcd_pkg.
module kmcd_dp #(
    parameter int MAX_ROWS = kmcd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = kmcd_pkg::DEF_MAX_COLS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kmcd_pkg::ADDR_W-1:0] paddr,
    input  logic [kmcd_pkg::DATA_W-1:0] pwdata,
    output logic [kmcd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        req_type,
    input  logic [3:0]                  column,
    input  logic [31:0]                 port_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        make,
    output logic [11:0]                 scancode,
    output logic                        last,
    input  kmcd_pkg::kmcd_cmd_t         cmd,
    output kmcd_pkg::kmcd_sts_t         sts
);
    import kmcd_pkg::*;

    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [CFG_W-1:0] row_first_reg;
    logic [CFG_W-1:0] row_count_reg;
    logic [CFG_W-1:0] col_count_reg;

    logic [MAX_ROWS-1:0] prev_rows_reg [MAX_COLS];
    logic [MAX_ROWS-1:0] now_reg;
    logic [MAX_ROWS-1:0] delta_reg;
    logic [MAX_ROWS-1:0] delta_next;
    logic [3:0]          col_reg;

    logic        out_valid_reg;
    logic        make_reg;
    logic [11:0] scancode_reg;
    logic        last_reg;

    logic [CFG_W-1:0]    nrows;
    logic [CFG_W-1:0]    ncols;
    logic [MAX_ROWS-1:0] rmask;
    logic [MAX_ROWS-1:0] now_rows;
    logic [MAX_ROWS-1:0] delta_in;
    logic                col_in_use;
    logic [RIW-1:0]      pick;
    logic                cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_ROW_FIRST: prdata = {{(DATA_W-CFG_W){1'b0}}, row_first_reg};
            REG_ROW_COUNT: prdata = {{(DATA_W-CFG_W){1'b0}}, row_count_reg};
            REG_COL_COUNT: prdata = {{(DATA_W-CFG_W){1'b0}}, col_count_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_first_reg <= ROW_FIRST_RST;
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROW_FIRST: row_first_reg <= pwdata[CFG_W-1:0];
                REG_ROW_COUNT: row_count_reg <= pwdata[CFG_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // saturate counts to the build limits
    assign nrows = (row_count_reg > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : row_count_reg;
    assign ncols = (col_count_reg > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : col_count_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            rmask[i] = (CFG_W'(i) < nrows);
        end
    end

    assign col_in_use = ({1'b0, column} < ncols);
    assign now_rows   = MAX_ROWS'(port_value >> row_first_reg) & rmask;
    // column is below MAX_COLS whenever col_in_use holds
    assign delta_in   = (now_rows ^ prev_rows_reg[column[CIW-1:0]]) & rmask;

    // lowest pending row
    always_comb
    begin
        pick = '0;
        for (int i = MAX_ROWS - 1; i >= 0; i--)
        begin
            if (delta_reg[i])
            begin
                pick = RIW'(i);
            end
        end
    end

    always_comb
    begin
        delta_next       = delta_reg;
        delta_next[pick] = 1'b0;
    end

    assign sts.hit       = col_in_use && (req_type == REQ_SCAN) && (delta_in != '0);
    assign sts.last      = (delta_next == '0);
    assign sts.out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                prev_rows_reg[c] <= '0;
            end
        end
        else if (cmd.load && col_in_use)
        begin
            prev_rows_reg[column[CIW-1:0]] <= now_rows;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg   <= now_rows;
            delta_reg <= delta_in;
            col_reg   <= column;
        end
        else if (cmd.emit)
        begin
            delta_reg <= delta_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            make_reg     <= now_reg[pick];
            scancode_reg <= {col_reg, 8'(pick)};
            last_reg     <= sts.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign make      = make_reg;
    assign scancode  = scancode_reg;
    assign last      = last_reg;

endmodule

>>> design/key_matrix_change_detector.sv
// Top level of the key matrix change detector: ties controller and datapath.
// Depends on kmcd_pkg, kmcd_ctrl and kmcd_dp.
//
// Each input beat carries the port word sampled for one matrix column. The
// block takes the beat while idle, stores the new row bits of that column
// at once, and then sends one key event per changed row, lowest row first,
// one event per cycle while the output is not stalled, from its change mask
// through a single output register; the final event of a sample has last
// set. in_stall holds the input, longer under output stalls, until the last
// event has entered the output register; a sample with no event (snapshot,
// no change, or a column at or above col_count) leaves the block idle.
// Configuration registers: row_first at 0x0, row_count at 0x4, col_count at
// 0x8; write them only while the block is idle.
module key_matrix_change_detector #(
    parameter int MAX_ROWS = kmcd_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = kmcd_pkg::DEF_MAX_COLS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kmcd_pkg::ADDR_W-1:0] paddr,
    input  logic [kmcd_pkg::DATA_W-1:0] pwdata,
    output logic [kmcd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [3:0]                  column,
    input  logic [31:0]                 port_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        make,
    output logic [11:0]                 scancode,
    output logic                        last
);
    import kmcd_pkg::*;

    kmcd_cmd_t cmd;
    kmcd_sts_t sts;

    kmcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    kmcd_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req_type   (req_type),
        .column     (column),
        .port_value (port_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .make       (make),
        .scancode   (scancode),
        .last       (last),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

>>> tb/key_matrix_change_detector_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for key_matrix_change_detector. It drives column samples
// and APB register writes, predicts the key events and checks every output beat.
// Depends on kmcd_pkg and the design sources.
module key_matrix_change_detector_tb;
    import kmcd_pkg::*;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         HOLD_LEN      = 300;
    localparam logic [1:0] REG_NONE      = 2'd3;

    typedef struct {
        logic        req;
        logic [3:0]  col;
        logic [31:0] port;
        int          gap;
        bit          drain;
    } sample_t;

    typedef struct packed {
        logic        make;
        logic [11:0] scancode;
        logic        last;
    } key_event_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              req_type   = REQ_SCAN;
    logic [3:0]        column     = '0;
    logic [31:0]       port_value = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              make;
    logic [11:0]       scancode;
    logic              last;

    key_matrix_change_detector u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .column     (column),
        .port_value (port_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .make       (make),
        .scancode   (scancode),
        .last       (last)
    );

    always #5 clk = ~clk;

    // Predictor state: register copies and the stored rows of every column
    logic [CFG_W-1:0] cfg_row_first = ROW_FIRST_RST;
    logic [CFG_W-1:0] cfg_row_count = ROW_COUNT_RST;
    logic [CFG_W-1:0] cfg_col_count = COL_COUNT_RST;
    logic [15:0]      stored_rows [DEF_MAX_COLS];
    logic [31:0]      last_port [DEF_MAX_COLS];

    key_event_t key_event_q [$];
    sample_t    pending_q [$];

    int n_queued  = 0;
    int n_sent    = 0;
    int n_events  = 0;
    int n_writes  = 0;
    int errors    = 0;
    int cycles    = 0;
    int stall_max = 0;
    int hold_at   = 0;

    function automatic int rows_used();
        return (cfg_row_count > 5'd16) ? DEF_MAX_ROWS : int'(cfg_row_count);
    endfunction

    function automatic int cols_used();
        return (cfg_col_count > 5'd16) ? DEF_MAX_COLS : int'(cfg_col_count);
    endfunction

    task automatic predict_key_events(sample_t s);
        int          nrows;
        int          total;
        int          k;
        logic [31:0] rmask;
        logic [15:0] now_rows;
        logic [15:0] delta;
        key_event_t  ev;
        nrows = rows_used();
        if (int'(s.col) >= cols_used())
            return;
        rmask = (32'h1 << nrows) - 32'h1;
        now_rows = 16'((s.port >> cfg_row_first) & rmask);
        if (s.req == REQ_SCAN)
        begin
            delta = (now_rows ^ stored_rows[s.col]) & rmask[15:0];
            total = $countones(delta);
            k = 0;
            for (int r = 0; r < nrows; r++)
            begin
                if (delta[r])
                begin
                    k++;
                    ev.make     = now_rows[r];
                    ev.scancode = {s.col, 8'(r)};
                    ev.last     = (k == total);
                    key_event_q.push_back(ev);
                end
            end
        end
        stored_rows[s.col] = now_rows;
    endtask

    // Sample driver
    sample_t staged;
    sample_t current;
    bit      staged_ok = 1'b0;
    int      gap_left  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            staged_ok = 1'b0;
            gap_left  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_key_events(current);
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (!staged_ok && pending_q.size() > 0)
                begin
                    staged    = pending_q.pop_front();
                    staged_ok = 1'b1;
                    gap_left  = staged.gap;
                end
                // a drain beat waits until every event so far has come out
                if (staged_ok && gap_left == 0 && (!staged.drain || key_event_q.size() == 0))
                begin
                    current    = staged;
                    staged_ok  = 1'b0;
                    in_valid   <= 1'b1;
                    req_type   <= staged.req;
                    column     <= staged.col;
                    port_value <= staged.port;
                end
                else
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Event monitor
    key_event_t want;
    key_event_t got;
    int         wait_left = 0;
    int         hold_left = 0;
    bit         hold_used = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            wait_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {make, scancode, last};
                if (key_event_q.size() == 0)
                begin
                    $display("%0t: unexpected event make=%0b scancode=%03h last=%0b",
                             $time, got.make, got.scancode, got.last);
                    errors++;
                end
                else
                begin
                    want = key_event_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected make=%0b scancode=%03h last=%0b, got make=%0b scancode=%03h last=%0b",
                                 $time, want.make, want.scancode, want.last,
                                 got.make, got.scancode, got.last);
                        errors++;
                    end
                end
                n_events++;
                wait_left = $urandom_range(0, stall_max);
            end
            else if (wait_left > 0)
                wait_left--;
            // hold off for a long stretch so the block backs up into its input
            if (!hold_used && hold_at > 0 && n_sent >= hold_at)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_LEN;
            end
            else if (hold_left > 0)
                hold_left--;
            out_stall <= (wait_left > 0) || (hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycles, key_event_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_sample(logic req, logic [3:0] col, logic [31:0] port,
                                int gap = 0, bit drain = 1'b0);
        sample_t s;
        s.req   = req;
        s.col   = col;
        s.port  = port;
        s.gap   = gap;
        s.drain = drain;
        pending_q.push_back(s);
        n_queued++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (n_sent != n_queued || key_event_q.size() != 0);
        // let a beat without events finish inside the block
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        logic [31:0] word;
        word = $urandom();
        word[CFG_W-1:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW_FIRST: cfg_row_first = value;
            REG_ROW_COUNT: cfg_row_count = value;
            REG_COL_COUNT: cfg_col_count = value;
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic set_config(logic [CFG_W-1:0] rf, logic [CFG_W-1:0] rc,
                              logic [CFG_W-1:0] cc);
        wait_idle();
        set_reg(REG_ROW_FIRST, rf);
        set_reg(REG_ROW_COUNT, rc);
        set_reg(REG_COL_COUNT, cc);
    endtask

    task automatic random_phase(int n_items, int gap_max, int stall_cap);
        int          taken;
        int          ncols;
        int          nrows;
        int          pick;
        logic [3:0]  col;
        logic [31:0] port;
        logic        req;
        stall_max = stall_cap;
        ncols = cols_used();
        nrows = rows_used();
        taken = 0;
        while (taken < n_items)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0 || ncols == 0)
                col = 4'($urandom_range(0, 15));
            else
                col = 4'($urandom_range(0, ncols - 1));
            req = (pick == 1) ? REQ_SNAPSHOT : REQ_SCAN;
            if (pick < 8)
                port = $urandom();
            else
            begin
                // flip one or two row lines so only a few keys change
                port = last_port[col];
                port ^= 32'h1 << (int'(cfg_row_first) + $urandom_range(0, nrows - 1));
                if (pick >= 14)
                    port ^= 32'h1 << (int'(cfg_row_first) + $urandom_range(0, nrows - 1));
            end
            last_port[col] = port;
            queue_sample(req, col, port, $urandom_range(0, gap_max), taken == n_items / 2);
            if (int'(col) < ncols)
                taken++;
        end
    endtask

    initial
    begin
        for (int c = 0; c < DEF_MAX_COLS; c++)
        begin
            stored_rows[c] = '0;
            last_port[c]   = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: eight rows from bit 0, eight columns
        queue_sample(REQ_SNAPSHOT, 4'd0, 32'h0000_00FF);
        queue_sample(REQ_SCAN, 4'd0, 32'h0000_0000);
        queue_sample(REQ_SCAN, 4'd0, 32'hFFFF_FFFF);
        queue_sample(REQ_SCAN, 4'd0, 32'h0000_00FF);
        queue_sample(REQ_SCAN, 4'd8, 32'h5555_AAAA);
        queue_sample(REQ_SCAN, 4'd15, 32'hFFFF_FFFF);
        queue_sample(REQ_SCAN, 4'd7, 32'h0000_00A5);
        queue_sample(REQ_SNAPSHOT, 4'd7, 32'h0000_005A);
        queue_sample(REQ_SCAN, 4'd7, 32'hFFFF_FF5A);

        // full sixteen rows in the upper half-word
        set_config(5'd16, 5'd16, 5'd16);
        queue_sample(REQ_SCAN, 4'd15, 32'hFFFF_0000);
        queue_sample(REQ_SCAN, 4'd15, 32'h0000_FFFF);
        queue_sample(REQ_SCAN, 4'd0, 32'hFFFF_FFFF);

        // saturated counts; rows past bit 31 read as zero
        set_config(5'd31, 5'd31, 5'd31);
        queue_sample(REQ_SCAN, 4'd3, 32'h8000_0000);
        queue_sample(REQ_SCAN, 4'd3, 32'h7FFF_FFFF);
        queue_sample(REQ_SCAN, 4'd14, 32'h8000_0000);

        // stale high bits from the sixteen-row setting drop without events
        set_config(5'd0, 5'd4, 5'd16);
        queue_sample(REQ_SCAN, 4'd0, 32'h0000_000F);
        set_config(5'd0, 5'd16, 5'd16);
        set_reg(REG_NONE, 5'd0);
        queue_sample(REQ_SCAN, 4'd0, 32'h0000_0003);

        // zero rows, then zero columns
        set_config(5'd0, 5'd0, 5'd16);
        queue_sample(REQ_SCAN, 4'd1, 32'hFFFF_FFFF);
        set_config(5'd0, 5'd8, 5'd0);
        queue_sample(REQ_SCAN, 4'd0, 32'hFFFF_FFFF);
        set_config(5'd0, 5'd8, 5'd1);
        queue_sample(REQ_SCAN, 4'd0, 32'h0000_0081);
        queue_sample(REQ_SCAN, 4'd1, 32'h0000_00FF);

        set_config(5'd0, 5'd16, 5'd16);
        random_phase(25, 10, 10);

        // back-to-back beats with a long output hold-off early in the phase
        set_config(5'($urandom_range(0, 16)), 5'($urandom_range(1, 16)),
                   5'($urandom_range(1, 16)));
        hold_at = n_sent + 3;
        random_phase(25, 0, 0);

        set_config(5'd16, 5'd16, 5'd16);
        random_phase(25, 10, 10);

        set_config(5'($urandom_range(0, 31)), 5'($urandom_range(17, 31)),
                   5'($urandom_range(17, 31)));
        random_phase(25, 4, 10);

        wait_idle();
        $display("covered %0d column samples and %0d key events over %0d register writes",
                 n_sent, n_events, n_writes);
        $display("directed edge cases plus four random settings, one with a long output hold-off");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
design/kmcd_pkg.sv
design/kmcd_ctrl.sv
design/kmcd_dp.sv
design/key_matrix_change_detector.sv
tb/key_matrix_change_detector_tb.sv
